@@ sv/ir_pulse_width_code_decoder_top_assert.svh @@
// Assertion macros for the IR pulse-width code decoder RTL.
// Included by the top level; the clock and the active-low reset are passed as macro arguments.
`ifndef IR_PULSE_WIDTH_CODE_DECODER_TOP_ASSERT_SVH
`define IR_PULSE_WIDTH_CODE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IRPWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("irpwd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define IRPWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("irpwd assertion failed");

`endif

@@ sv/irpwd_pkg.sv @@
// Package for the IR pulse-width code decoder: widths, register indexes,
// reset values and the interval and button match functions. No dependencies.
`timescale 1ns / 1ps

package irpwd_pkg;

  localparam int MARK_W      = 8;
  localparam int CODE_W      = 11;
  localparam int CNT_OUT_W   = 4;
  localparam int IDX_W       = 3;
  localparam int BTN_N       = 5;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef logic [MARK_W-1:0] mark_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0]  btn_idx_t;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_START_MARK = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_MARK   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MARK  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BTN_A      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BTN_B      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BTN_C      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BTN_D      = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BTN_E      = 3'd7;

  localparam mark_t START_MARK_RST = 8'h1C;
  localparam mark_t ONE_MARK_RST   = 8'h10;
  localparam mark_t ZERO_MARK_RST  = 8'h0A;
  localparam code_t BTN_A_RST      = 11'h178;
  localparam code_t BTN_B_RST      = 11'h578;
  localparam code_t BTN_C_RST      = 11'h168;
  localparam code_t BTN_D_RST      = 11'h538;
  localparam code_t BTN_E_RST      = 11'h668;

  typedef code_t btn_table_t [BTN_N];

  // Interval matches mark or mark+1; the +1 is taken in 9 bits so 255 has no partner.
  function automatic logic pair_match(input mark_t v, input mark_t mark);
    logic [MARK_W:0] v_x;
    logic [MARK_W:0] m_x;
    v_x = {1'b0, v};
    m_x = {1'b0, mark};
    return (v_x == m_x) || (v_x == (m_x + 1'b1));
  endfunction

  // Lowest matching button wins; 0 when nothing matches.
  function automatic btn_idx_t btn_lookup(input code_t c, input btn_table_t tbl);
    btn_idx_t idx;
    idx = '0;
    for (int i = BTN_N - 1; i >= 0; i--) begin
      if (tbl[i] == c) begin
        idx = IDX_W'(i + 1);
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/ir_pulse_width_code_decoder_top.sv @@
// Top level of the IR pulse-width code decoder: input register, frame state,
// bit decode, button lookup and output register. Depends on irpwd_pkg and the assert header.
`timescale 1ns / 1ps
`include "ir_pulse_width_code_decoder_top_assert.svh"

// Usage
//   in_*  : one item per measured interval; in_tdata[7:0] is the high byte of
//           the interval measured between falling edges of the IR receiver.
//   out_* : one item per finished frame; out_tdata carries code, bit count and
//           the matching button index (0 when no button register matches).
//   cfg_* : write-only register port, to be written only while the decoder is idle (not enforced).
// Timing
//   Throughput is one item per clock while a low out_tready does not hold the output.
//   An item is registered in the input register when it is accepted and is decoded
//   from there into the frame state and the output register, which drives out_tvalid.
//   There is a single decode stage (six 9-bit compares, an 11-bit shift and
//   five 11-bit button compares).
// Reset
//   rst_n low clears both valid flags and the frame state (idle, no bits) and
//   loads the default marks and button codes.
// Backpressure
//   When out_tready is low with a result waiting, the decode stage holds; the
//   input register still takes one more item if it is empty, then in_tready drops
//   until the result is taken.
module ir_pulse_width_code_decoder_top #(
  parameter int FRAME_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Interval items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [irpwd_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] interval_high
  // Decoded frame items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [irpwd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [10:0] code, [14:11] bits_received,
                                                          // [17:15] button_index, [23:18] zero
  // Register writes
  input  logic                                cfg_wr_en,
  input  logic [irpwd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [irpwd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import irpwd_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  // Configuration registers
  mark_t      start_mark_r;
  mark_t      one_mark_r;
  mark_t      zero_mark_r;
  btn_table_t btn_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_r  <= START_MARK_RST;
      one_mark_r    <= ONE_MARK_RST;
      zero_mark_r   <= ZERO_MARK_RST;
      btn_code_r[0] <= BTN_A_RST;
      btn_code_r[1] <= BTN_B_RST;
      btn_code_r[2] <= BTN_C_RST;
      btn_code_r[3] <= BTN_D_RST;
      btn_code_r[4] <= BTN_E_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_START_MARK: start_mark_r  <= cfg_wdata[MARK_W-1:0];
        REG_ONE_MARK:   one_mark_r    <= cfg_wdata[MARK_W-1:0];
        REG_ZERO_MARK:  zero_mark_r   <= cfg_wdata[MARK_W-1:0];
        REG_BTN_A:      btn_code_r[0] <= cfg_wdata[CODE_W-1:0];
        REG_BTN_B:      btn_code_r[1] <= cfg_wdata[CODE_W-1:0];
        REG_BTN_C:      btn_code_r[2] <= cfg_wdata[CODE_W-1:0];
        REG_BTN_D:      btn_code_r[3] <= cfg_wdata[CODE_W-1:0];
        REG_BTN_E:      btn_code_r[4] <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic  in_valid_r;
  mark_t in_data_r;
  logic  out_valid_r;
  logic  [OUT_TDATA_W-1:0] out_data_r;

  // The decode stage advances whenever the output register is free or draining.
  logic advance;
  logic proc_go;
  assign advance   = !out_valid_r || out_tready;
  assign proc_go   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[MARK_W-1:0];
    end
  end

  // Frame state
  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] bit_cnt_r,  bit_cnt_nxt;
  code_t            code_r,     code_nxt;

  // Decode
  logic             is_start, is_one, is_zero;
  code_t            code_shift;
  logic [CNT_W-1:0] cnt_inc;
  logic             res_valid;
  code_t            res_code;
  logic [CNT_W-1:0] res_cnt;

  always_comb begin
    is_start   = pair_match(in_data_r, start_mark_r);
    is_one     = pair_match(in_data_r, one_mark_r);
    is_zero    = pair_match(in_data_r, zero_mark_r);
    // One pair wins when it overlaps the zero pair.
    code_shift = {code_r[CODE_W-2:0], is_one};
    cnt_inc    = bit_cnt_r + 1'b1;

    in_frame_nxt = in_frame_r;
    bit_cnt_nxt  = bit_cnt_r;
    code_nxt     = code_r;
    res_valid    = 1'b0;
    res_code     = code_r;
    res_cnt      = bit_cnt_r;

    if (!in_frame_r) begin
      // Idle: only a start interval opens a frame, and it yields no item.
      if (is_start) begin
        in_frame_nxt = 1'b1;
      end
    end else if (is_one || is_zero) begin
      if (cnt_inc >= CNT_W'(FRAME_BITS)) begin
        // Full frame: report and go idle.
        res_valid    = 1'b1;
        res_code     = code_shift;
        res_cnt      = cnt_inc;
        in_frame_nxt = 1'b0;
        bit_cnt_nxt  = '0;
        code_nxt     = '0;
      end else begin
        bit_cnt_nxt = cnt_inc;
        code_nxt    = code_shift;
      end
    end else begin
      // Unrecognized interval: end the frame early with what came so far.
      res_valid    = 1'b1;
      in_frame_nxt = 1'b0;
      bit_cnt_nxt  = '0;
      code_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      bit_cnt_r  <= '0;
      code_r     <= '0;
    end else if (proc_go) begin
      in_frame_r <= in_frame_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      code_r     <= code_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_valid) begin
      out_data_r <= {{(OUT_TDATA_W - CODE_W - CNT_OUT_W - IDX_W){1'b0}},
                     btn_lookup(res_code, btn_code_r),
                     CNT_OUT_W'(res_cnt),
                     res_code};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `IRPWD_ASSERT_IMPL(a_idle_clean, clk, rst_n, !in_frame_r,
                     (bit_cnt_r == '0) && (code_r == '0))
  `IRPWD_ASSERT_IMPL(a_cnt_below_frame, clk, rst_n, in_frame_r,
                     bit_cnt_r < CNT_W'(FRAME_BITS))
  `IRPWD_ASSERT_IMPL(a_result_from_frame, clk, rst_n, proc_go && res_valid, in_frame_r)
  `IRPWD_ASSERT_NEXT(a_result_closes_frame, clk, rst_n, proc_go && res_valid,
                     !in_frame_r && out_valid_r)

endmodule
